@@ rtl/vtp_pkg.sv @@
// Shared types, constants and arithmetic helpers for the vertex transform block.
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int VIEW_WIDTH  = 800;
  localparam int VIEW_HEIGHT = 600;
  localparam int DIV_BITS    = 48;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int MAT_ENTRIES = 12;

  localparam logic       FUNC_LOAD    = 1'b0;
  localparam logic [1:0] COL_UNUSED   = 2'd3;
  localparam logic [1:0] REG_PROJ_X   = 2'd0;
  localparam logic [1:0] REG_PROJ_Y   = 2'd1;
  localparam logic [1:0] REG_DEPTH_SC = 2'd2;
  localparam logic [1:0] REG_DEPTH_OF = 2'd3;

  localparam logic signed [31:0] PROJ_X_RST   = 32'sd87381;
  localparam logic signed [31:0] PROJ_Y_RST   = 32'sd65536;
  localparam logic signed [31:0] DEPTH_SC_RST = 32'sd65601;
  localparam logic signed [31:0] DEPTH_OF_RST = -32'sd6560;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [63:0] MAX64   = 64'sd2147483647;
  localparam logic signed [63:0] MIN64   = -64'sd2147483648;

  // One queued word: either a matrix load or a vertex.
  typedef struct packed {
    logic               load;
    logic [3:0]         idx;
    logic signed [31:0] a;   // coefficient for a load, vertex x otherwise
    logic signed [31:0] b;
    logic signed [31:0] c;
  } vtp_entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX64) r = S32_MAX;
    else if (v < MIN64) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] smul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] xe;
    logic signed [63:0] ye;
    xe = x;
    ye = y;
    return xe * ye;
  endfunction

endpackage

@@ rtl/vertex_transform_project_viewport.sv @@
// Top level of the vertex transform, perspective divide and viewport block.
//
// Input words (in_*) are either world-matrix loads (in_tuser low) or
// vertices (in_tuser high). A load writes one Q16.16 coefficient and
// produces no output; a load to the fourth column is dropped. Each vertex
// produces one output word with screen x, screen y, depth and a flag that
// is set when the world z was zero.
// One word is accepted per cycle while the queue is not full or the input
// register is empty. A vertex passes the matrix and projection stages, the
// 48-stage bit-per-stage divider that performs the perspective divide, and
// the viewport stages. Loads pass through the same queue so they apply in order.
// While out_tready is low on a valid output the whole pipeline holds;
// the input keeps accepting until the four-entry queue and input register fill.
// Reset clears the matrix to zero and loads the projection registers with
// their defaults. Configuration writes go through cfg_* while idle.
`timescale 1ns / 1ps
module vertex_transform_project_viewport (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row, column, coefficient, vertex_x, vertex_y, vertex_z, zero pad
  input  logic [135:0] in_tdata,
  // func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // screen_x, screen_y, depth
  output logic [95:0]  out_tdata,
  // w_zero
  output logic         out_tuser
);
  import vtp_pkg::*;

  logic       push, full, pop, empty;
  vtp_entry_t push_data, pop_data;

  vtp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .push(push),
    .push_data(push_data), .full(full)
  );

  vtp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .empty(empty)
  );

  vtp_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .pop_data(pop_data), .empty(empty), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_wzero_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == 32'h7fffffff)
    else $error("off-screen x not saturated");

  a_wzero_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:32] == 32'h80000000)
    else $error("off-screen y not saturated");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

endmodule

@@ rtl/vtp_front.sv @@
// Input stage: accepts words, drops unused loads and forms queue entries.
`timescale 1ns / 1ps
module vtp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [135:0]       in_tdata,
  input  logic               in_tuser,
  output logic               push,
  output vtp_pkg::vtp_entry_t push_data,
  input  logic               full
);
  import vtp_pkg::*;

  logic       vld_r, vld_nxt;
  vtp_entry_t ent_r;
  logic       acc, keep;
  logic [1:0] row, col;

  assign row       = in_tdata[1:0];
  assign col       = in_tdata[3:2];
  assign push      = vld_r && !full;
  assign push_data = ent_r;
  assign in_tready = !vld_r || !full;
  assign acc       = in_tvalid && in_tready;
  // A load aimed at the fourth column has nowhere to go.
  assign keep      = !(in_tuser == FUNC_LOAD && col == COL_UNUSED);

  always_comb begin
    vld_nxt = vld_r;
    if (push) vld_nxt = 1'b0;
    if (acc && keep) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ent_r.load <= (in_tuser == FUNC_LOAD);
      ent_r.idx  <= 4'({row, 1'b0}) + 4'(row) + 4'(col);
      ent_r.a    <= (in_tuser == FUNC_LOAD) ? in_tdata[35:4] : in_tdata[67:36];
      ent_r.b    <= in_tdata[99:68];
      ent_r.c    <= in_tdata[131:100];
    end
  end

endmodule

@@ rtl/vtp_fifo.sv @@
// Short queue between the input stage and the arithmetic pipeline.
`timescale 1ns / 1ps
module vtp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vtp_pkg::vtp_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output vtp_pkg::vtp_entry_t pop_data,
  output logic                empty
);
  import vtp_pkg::*;

  vtp_entry_t         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && !empty)) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop && !empty) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

endmodule

@@ rtl/vtp_div.sv @@
// Pipelined unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module vtp_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vtp_pkg::DIV_BITS-1:0] num_in,
  input  logic [31:0]                  den_in,
  output logic [vtp_pkg::DIV_BITS-1:0] quo_out
);
  import vtp_pkg::*;

  logic [31:0]         rem_r [DIV_BITS];
  logic [DIV_BITS-1:0] num_r [DIV_BITS];
  logic [31:0]         den_r [DIV_BITS];

  assign quo_out = num_r[DIV_BITS-1];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [31:0]         rem_s, den_s;
    logic [DIV_BITS-1:0] num_s;
    logic [32:0]         trial;
    logic                qbit;
    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign num_s = num_in;
      assign den_s = den_in;
    end else begin : g_next
      assign rem_s = rem_r[k-1];
      assign num_s = num_r[k-1];
      assign den_s = den_r[k-1];
    end
    assign trial = {rem_s, num_s[DIV_BITS-1]} - {1'b0, den_s};
    assign qbit  = !trial[32];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= qbit ? trial[31:0] : {rem_s[30:0], num_s[DIV_BITS-1]};
        num_r[k] <= {num_s[DIV_BITS-2:0], qbit};
        den_r[k] <= den_s;
      end
    end
  end

endmodule

@@ rtl/vtp_back.sv @@
// Arithmetic pipeline: matrix, projection, perspective divide and viewport.
`timescale 1ns / 1ps
module vtp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  vtp_pkg::vtp_entry_t pop_data,
  input  logic                empty,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [95:0]         out_tdata,
  output logic                out_tuser
);
  import vtp_pkg::*;

  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic               wzero;
    logic signed [31:0] pz;
  } vtp_side_t;

  logic signed [31:0] psx_r, psy_r, dsc_r, dof_r;
  logic signed [31:0] mat_r [MAT_ENTRIES];
  logic               en;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, vo_r;
  logic signed [63:0] prod_r [9];
  logic signed [31:0] tr_r [3];
  logic signed [65:0] sum_r [3];
  logic signed [31:0] tr2_r [3];
  logic signed [31:0] w_r [3];
  logic signed [63:0] mx_r, my_r, mz_r;
  logic signed [31:0] wz4_r;
  logic signed [31:0] px_r, py_r, pz_r, wz5_r;
  logic [DIV_BITS-1:0] dnx_r, dny_r, dnz_r;
  logic [31:0]        dden_r;
  vtp_side_t          sd6_r;
  vtp_side_t          sd_r [DIV_BITS];
  logic               sdv_r [DIV_BITS];
  logic [DIV_BITS-1:0] qx, qy, qz;
  logic signed [31:0] nx_r, ny_r, dz7_r;
  logic               wz7_r;
  logic signed [63:0] vxp_r, vyp_r;
  logic signed [31:0] dz8_r;
  logic               wz8_r;
  logic signed [31:0] sx_r, sy_r, dz_r;
  logic               wzo_r;

  // The whole pipeline advances together unless the result is held.
  assign en         = !(vo_r && !out_tready);
  assign pop        = en && !empty;
  assign out_tvalid = vo_r;
  assign out_tdata  = {dz_r, sy_r, sx_r};
  assign out_tuser  = wzo_r;

  function automatic logic signed [31:0] sat_quo(input logic [DIV_BITS-1:0] q,
                                                 input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (q > DIV_BITS'(33'h080000000)) r = S32_MIN;
      else r = ~q[31:0] + 32'd1;
    end else begin
      if (q > DIV_BITS'(33'h07fffffff)) r = S32_MAX;
      else r = q[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psx_r <= PROJ_X_RST;
      psy_r <= PROJ_Y_RST;
      dsc_r <= DEPTH_SC_RST;
      dof_r <= DEPTH_OF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROJ_X:   psx_r <= cfg_wdata;
        REG_PROJ_Y:   psy_r <= cfg_wdata;
        REG_DEPTH_SC: dsc_r <= cfg_wdata;
        REG_DEPTH_OF: dof_r <= cfg_wdata;
        default:      psx_r <= psx_r;
      endcase
    end
  end

  // Loads take effect in queue order, so every vertex sees the matrix
  // as it stood when that vertex arrived.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_ENTRIES; i++) mat_r[i] <= '0;
    end else if (pop && pop_data.load) begin
      mat_r[pop_data.idx] <= pop_data.a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; vo_r <= 1'b0;
      for (int i = 0; i < DIV_BITS; i++) sdv_r[i] <= 1'b0;
    end else if (en) begin
      v1_r <= pop && !pop_data.load;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      sdv_r[0] <= v6_r;
      for (int i = 1; i < DIV_BITS; i++) sdv_r[i] <= sdv_r[i-1];
      v7_r <= sdv_r[DIV_BITS-1];
      v8_r <= v7_r;
      vo_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Products of the vertex with the 3x3 part of the matrix.
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r*3+c] <= smul((r == 0) ? pop_data.a : (r == 1) ? pop_data.b
                                : pop_data.c, mat_r[r*3+c]);
        end
      end
      for (int c = 0; c < 3; c++) tr_r[c] <= mat_r[9+c];

      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= 66'(prod_r[c]) + 66'(prod_r[3+c]) + 66'(prod_r[6+c]);
        tr2_r[c] <= tr_r[c];
      end

      for (int c = 0; c < 3; c++) begin
        w_r[c] <= sat32($signed(64'(((sum_r[c] + 66'sd32768) >>> 16)
                                    + 66'(tr2_r[c]))));
      end

      mx_r  <= smul(w_r[0], psx_r);
      my_r  <= smul(w_r[1], psy_r);
      mz_r  <= smul(w_r[2], dsc_r);
      wz4_r <= w_r[2];

      px_r  <= sat32((mx_r + 64'sd32768) >>> 16);
      py_r  <= sat32((my_r + 64'sd32768) >>> 16);
      pz_r  <= sat32(((mz_r + 64'sd32768) >>> 16) + 64'(dof_r));
      wz5_r <= wz4_r;

      dnx_r        <= {mag32(px_r), 16'd0};
      dny_r        <= {mag32(py_r), 16'd0};
      dnz_r        <= {mag32(pz_r), 16'd0};
      dden_r       <= mag32(wz5_r);
      sd6_r.neg_x  <= px_r[31] ^ wz5_r[31];
      sd6_r.neg_y  <= py_r[31] ^ wz5_r[31];
      sd6_r.neg_z  <= pz_r[31] ^ wz5_r[31];
      sd6_r.wzero  <= (wz5_r == '0);
      sd6_r.pz     <= pz_r;

      sd_r[0] <= sd6_r;
      for (int i = 1; i < DIV_BITS; i++) sd_r[i] <= sd_r[i-1];

      nx_r  <= sat_quo(qx, sd_r[DIV_BITS-1].neg_x);
      ny_r  <= sat_quo(qy, sd_r[DIV_BITS-1].neg_y);
      dz7_r <= sd_r[DIV_BITS-1].wzero ? sd_r[DIV_BITS-1].pz
               : sat_quo(qz, sd_r[DIV_BITS-1].neg_z);
      wz7_r <= sd_r[DIV_BITS-1].wzero;

      vxp_r <= (64'(nx_r) + 64'sd65536) * 64'(VIEW_WIDTH);
      vyp_r <= (64'sd65536 - 64'(ny_r)) * 64'(VIEW_HEIGHT);
      dz8_r <= dz7_r;
      wz8_r <= wz7_r;

      // An off-screen point lands beyond any viewport on both axes.
      sx_r  <= wz8_r ? S32_MAX : sat32((vxp_r + 64'sd1) >>> 1);
      sy_r  <= wz8_r ? S32_MIN : sat32((vyp_r + 64'sd1) >>> 1);
      dz_r  <= dz8_r;
      wzo_r <= wz8_r;
    end
  end

  vtp_div u_div_x (.clk(clk), .en(en), .num_in(dnx_r), .den_in(dden_r), .quo_out(qx));
  vtp_div u_div_y (.clk(clk), .en(en), .num_in(dny_r), .den_in(dden_r), .quo_out(qy));
  vtp_div u_div_z (.clk(clk), .en(en), .num_in(dnz_r), .den_in(dden_r), .quo_out(qz));

endmodule

@@ tb/sv/tb_vertex_transform_project_viewport.sv @@
// Testbench for the vertex transform, projection and viewport block.
`timescale 1ns / 1ps
module tb_vertex_transform_project_viewport;
  import vtp_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // row, column, coefficient, vertex_x, vertex_y, vertex_z, zero pad
  logic [135:0] in_tdata = '0;
  // func
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // screen_x, screen_y, depth
  logic [95:0]  out_tdata;
  // w_zero
  logic         out_tuser;

  vertex_transform_project_viewport uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] dp;
    logic               wz;
  } screen_pt_t;

  screen_pt_t pending_pts[$];
  longint matrix_m[12];
  longint px_scale, py_scale, dz_scale, dz_offset;
  int errors = 0;
  int hold_cycles = 0;   // when nonzero the receiver holds out_tready low while it counts down
  bit stall_out = 1'b1;

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qdiv(longint p, longint w);
    return clamp32((p * 65536) / w);
  endfunction

  function automatic longint world_axis(longint vx, longint vy, longint vz, int col);
    longint v[3];
    longint hi, lo, p, h;
    v[0] = vx; v[1] = vy; v[2] = vz;
    hi = 0; lo = 0;
    for (int r = 0; r < 3; r++) begin
      p = v[r] * matrix_m[r * 3 + col];
      h = fl_shr(p, 16);
      hi += h;
      lo += p - h * 65536;
    end
    hi += fl_shr(lo + 32768, 16);
    return clamp32(hi + matrix_m[9 + col]);
  endfunction

  function automatic screen_pt_t project_vertex(longint vx, longint vy, longint vz);
    screen_pt_t e;
    longint wx, wy, wzv, px, py, pz, nx, ny;
    wx = world_axis(vx, vy, vz, 0);
    wy = world_axis(vx, vy, vz, 1);
    wzv = world_axis(vx, vy, vz, 2);
    px = clamp32(fl_shr(wx * px_scale + 32768, 16));
    py = clamp32(fl_shr(wy * py_scale + 32768, 16));
    pz = clamp32(fl_shr(wzv * dz_scale + 32768, 16) + dz_offset);
    e.wz = (wzv == 0);
    if (!e.wz) begin
      nx = qdiv(px, wzv);
      ny = qdiv(py, wzv);
      pz = qdiv(pz, wzv);
    end else begin
      nx = 64'sd100000 * 65536;
      ny = nx;
    end
    e.sx = clamp32(fl_shr((nx + 65536) * VIEW_WIDTH + 1, 1));
    e.sy = clamp32(fl_shr((65536 - ny) * VIEW_HEIGHT + 1, 1));
    e.dp = pz;
    return e;
  endfunction

  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PROJ_X:   px_scale  = longint'(signed'(val));
      REG_PROJ_Y:   py_scale  = longint'(signed'(val));
      REG_DEPTH_SC: dz_scale  = longint'(signed'(val));
      default:      dz_offset = longint'(signed'(val));
    endcase
  endtask

  // A nonzero gap drops in_tvalid first, then idles.
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (n > 0) in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sends one word; in_tvalid stays high if another word follows directly.
  task automatic send_word(logic func, logic [1:0] row, logic [1:0] col,
                           logic [31:0] coef, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz, bit gaps);
    if (gaps) random_gap();
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0, vz, vy, vx, coef, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (func == FUNC_LOAD) begin
      if (col != COL_UNUSED) matrix_m[row * 3 + col] = longint'(signed'(coef));
    end else begin
      pending_pts.push_back(project_vertex(signed'(vx), signed'(vy), signed'(vz)));
    end
  endtask

  task automatic send_load(int r, int c, logic [31:0] coef, bit gaps = 1);
    send_word(FUNC_LOAD, r[1:0], c[1:0], coef, $urandom, $urandom, $urandom, gaps);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps = 1);
    send_word(~FUNC_LOAD, 2'($urandom), 2'($urandom), $urandom, x, y, z, gaps);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(0, 32'h3ffff) - 32'h20000;
    endcase
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (!stall_out) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    screen_pt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        e = pending_pts.pop_front();
        if (out_tdata[31:0] !== e.sx) begin
          $error("screen_x expected %0d actual %0d", e.sx, $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tdata[63:32] !== e.sy) begin
          $error("screen_y expected %0d actual %0d", e.sy, $signed(out_tdata[63:32]));
          errors++;
        end
        if (out_tdata[95:64] !== e.dp) begin
          $error("depth expected %0d actual %0d", e.dp, $signed(out_tdata[95:64]));
          errors++;
        end
        if (out_tuser !== e.wz) begin
          $error("w_zero expected %0d actual %0d", e.wz, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // Identity matrix first, then the z translation, two off-diagonal coefficients and the ignored column.
    for (int r = 0; r < 3; r++) send_load(r, r, 32'h10000);
    send_load(3, 2, 32'h50000);
    send_vertex(32'h10000, 32'h10000, 32'h10000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_load(3, 2, 32'h0);
    send_vertex(32'h20000, 32'hfffe0000, 32'h0);       // zero w
    send_load(1, 3, 32'h7fffffff);                      // ignored column
    send_vertex(32'h8000, 32'h8000, 32'h8000);
    send_load(0, 1, 32'h7fffffff);
    send_load(2, 0, 32'h80000000);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_vertex(32'hffffffff, 32'h1, 32'h1);
    drain();
  endtask

  task automatic test_config_extremes();
    set_reg(REG_PROJ_X, 32'h7fffffff);
    set_reg(REG_PROJ_Y, 32'h80000000);
    set_reg(REG_DEPTH_SC, 32'h0);
    set_reg(REG_DEPTH_OF, 32'h80000000);
    for (int i = 0; i < 8; i++) send_vertex(rand_q16(), rand_q16(), rand_q16());
    drain();
    set_reg(REG_PROJ_X, 32'h80000000);
    set_reg(REG_PROJ_Y, 32'h7fffffff);
    set_reg(REG_DEPTH_SC, 32'h7fffffff);
    set_reg(REG_DEPTH_OF, 32'h7fffffff);
    for (int i = 0; i < 8; i++) send_vertex(rand_q16(), rand_q16(), rand_q16());
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_load($urandom_range(0, 3), $urandom_range(0, 3), rand_q16());
      else if ($urandom_range(0, 9) == 0)
        send_vertex(32'h0, 32'h0, 32'h0);
      else
        send_vertex(rand_q16(), rand_q16(), rand_q16());
    end
  endtask

  task automatic test_backpressure();
    // More words than the pipeline and queue hold, so the input stalls.
    hold_cycles = 300;
    for (int i = 0; i < 100; i++) send_vertex(rand_q16(), rand_q16(), rand_q16(), 0);
    drain();
    // Sender waits for every result, then a burst with the receiver always ready.
    stall_out = 1'b0;
    for (int i = 0; i < 40; i++) send_vertex(rand_q16(), rand_q16(), rand_q16(), 0);
    drain();
    stall_out = 1'b1;
  endtask

  initial begin
    px_scale = 87381; py_scale = 65536; dz_scale = 65601; dz_offset = -6560;
    foreach (matrix_m[i]) matrix_m[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    set_reg(REG_PROJ_X, 32'd87381);
    set_reg(REG_PROJ_Y, 32'd65536);
    set_reg(REG_DEPTH_SC, 32'd65601);
    set_reg(REG_DEPTH_OF, -32'sd6560);
    test_random(700);
    drain();
    test_backpressure();
    set_reg(REG_PROJ_X, $urandom);
    set_reg(REG_PROJ_Y, $urandom_range(0, 32'h40000));
    set_reg(REG_DEPTH_SC, $urandom);
    set_reg(REG_DEPTH_OF, $urandom);
    test_random(800);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/vtp_pkg.sv
rtl/vtp_front.sv
rtl/vtp_fifo.sv
rtl/vtp_div.sv
rtl/vtp_back.sv
rtl/vertex_transform_project_viewport.sv
tb/sv/tb_vertex_transform_project_viewport.sv
